FILE: hw/rtl/max_profit_k_trades_dp_top_assert.svh
// Assertion macros for the max_profit_k_trades_dp block.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef MAX_PROFIT_K_TRADES_DP_TOP_ASSERT_SVH
`define MAX_PROFIT_K_TRADES_DP_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define MPK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mpk_dp_pkg.sv
// Shared widths and defaults for the max_profit_k_trades_dp block.
// No dependencies; used by max_profit_k_trades_dp_top.
package mpk_dp_pkg;

	localparam int MAX_LEN_DEF = 1024;
	localparam int PRICE_W     = 16;
	localparam int PROFIT_W    = 26;
	localparam int TRADES_W    = 10;
	// Signed working width for buy and sell sums.
	localparam int ACC_W       = 28;
	localparam int CFG_AW      = 3;
	localparam int CFG_DW      = 32;
	localparam int OUT_DW      = 32;

	localparam logic [TRADES_W-1:0] TRADES_RST = TRADES_W'(1);

endpackage

FILE: hw/rtl/max_profit_k_trades_dp_top.sv
// Top level of the max_profit_k_trades_dp block: price store, row store and sequencer.
// Depends on mpk_dp_pkg and max_profit_k_trades_dp_top_assert.svh.
//
// Prices are loaded one per cycle over the slave stream and stored in order (prices beyond
// MAX_LEN are dropped). The request marked with tlast closes the sequence; the block then
// stops taking requests and runs the trade table row by row, at most max_trades rows, each
// row walking the N stored prices with a single shared adder and comparator that is used
// twice per price. Rows are computed until max_trades rows are done or, earlier, until a row
// repeats the one before it. A single price or max_trades of zero gives a zero profit
// without running any row.
// No clearing pass is needed after reset. One profit result is then offered on the master
// stream and the block is ready for the next sequence; loading may start while that result
// still waits to be taken.
`include "max_profit_k_trades_dp_top_assert.svh"

module max_profit_k_trades_dp_top #(
	parameter int MAX_LEN = mpk_dp_pkg::MAX_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Slave stream: tdata = price[15:0]
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mpk_dp_pkg::PRICE_W-1:0]  s_tdata,
	input  logic                            s_tlast,
	// Master stream: tdata = profit[25:0], zero filled to 32 bits
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mpk_dp_pkg::OUT_DW-1:0]   m_tdata,
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mpk_dp_pkg::CFG_AW-1:0]   paddr,
	input  logic [mpk_dp_pkg::CFG_DW-1:0]   pwdata,
	output logic [mpk_dp_pkg::CFG_DW-1:0]   prdata,
	output logic                            pready
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int PW = mpk_dp_pkg::PRICE_W;
	localparam int RW = mpk_dp_pkg::PROFIT_W;
	localparam int TW = mpk_dp_pkg::TRADES_W;
	localparam int XW = mpk_dp_pkg::ACC_W;
	localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LEN);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_SELL  = 3'd2;
	localparam logic [2:0] ST_BUY   = 3'd3;
	localparam logic [2:0] ST_TAIL  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam string msg_a_done_presents = "result not presented after the run finished";
	localparam string msg_a_short_run     = "short sequence did not give a zero profit";

	logic [2:0]           state_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        e_q;
	logic [TW-1:0]        rows_q;
	logic [TW-1:0]        max_trades_q;
	logic                 first_row_q;
	logic                 changed_q;
	logic signed [XW-1:0] best_q;
	logic [RW-1:0]        keep_q;
	logic [RW-1:0]        result_q;
	logic                 out_valid_q;
	logic [RW-1:0]        out_profit_q;

	logic [PW-1:0]        price_mem [MAX_LEN];
	logic [RW-1:0]        row_mem   [MAX_LEN];
	logic [PW-1:0]        price_rd_q;
	logic [RW-1:0]        row_rd_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 cfg_wr;
	logic [CW-1:0]        last_cnt;
	logic [AW-1:0]        last_idx;
	logic                 at_last;
	logic                 short_run;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        row_raddr;
	logic                 row_we;
	logic [AW-1:0]        row_waddr;
	logic [RW-1:0]        prev_old;
	logic                 differs;
	logic                 rows_done;
	logic signed [XW-1:0] op_a;
	logic signed [XW-1:0] op_b;
	logic signed [XW-1:0] op_c;
	logic signed [XW-1:0] sum;
	logic                 gt;

	assign in_acc    = s_tvalid & s_tready;
	assign s_tready  = (state_q == ST_LOAD);
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(mpk_dp_pkg::OUT_DW - RW){1'b0}}, out_profit_q};
	assign last_cnt  = count_q - 1'b1;
	assign last_idx  = last_cnt[AW-1:0];
	assign at_last   = (e_q == last_idx);
	assign short_run = (count_q < CW'(2)) || (max_trades_q == '0);
	assign rows_done = ((rows_q + 1'b1) == max_trades_q);

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == 1'b0) ?
		{{(mpk_dp_pkg::CFG_DW - TW){1'b0}}, max_trades_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_trades_q <= mpk_dp_pkg::TRADES_RST;
		end else if (cfg_wr && (paddr[2] == 1'b0)) begin
			max_trades_q <= pwdata[TW-1:0];
		end
	end

	// The row store is updated in place: the previous row's entry is read before
	// the current row's value overwrites it. The first row reads it as zero.
	always_comb begin
		case (state_q)
			ST_BUY:               rd_addr = at_last ? e_q : e_q + 1'b1;
			ST_START, ST_TAIL:    rd_addr = '0;
			default:              rd_addr = e_q;
		endcase
	end

	// The row read trails the price read by one entry, so that both the sell and the
	// buy step at entry e see the previous row's value at e - 1.
	always_comb begin
		case (state_q)
			ST_SELL:              row_raddr = (e_q == '0) ? '0 : e_q - 1'b1;
			default:              row_raddr = e_q;
		endcase
	end

	assign prev_old  = first_row_q ? '0 : row_rd_q;
	assign differs   = (keep_q != prev_old);
	assign row_we    = ((state_q == ST_SELL) && (e_q != '0)) || (state_q == ST_TAIL);
	assign row_waddr = (state_q == ST_TAIL) ? e_q : e_q - 1'b1;

	always_ff @(posedge clk) begin
		if (in_acc && (count_q < MAX_LEN_C)) begin
			price_mem[count_q[AW-1:0]] <= s_tdata;
		end
		price_rd_q <= price_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= keep_q;
		end
		row_rd_q <= row_mem[row_raddr];
	end

	// Shared adder and comparator: sell candidate in ST_SELL, buy candidate in ST_BUY.
	always_comb begin
		if (state_q == ST_SELL) begin
			op_a = XW'(signed'({1'b0, price_rd_q}));
			op_b = best_q;
			op_c = XW'(signed'({1'b0, keep_q}));
		end else begin
			op_a = (e_q == '0) ? '0 : XW'(signed'({1'b0, prev_old}));
			op_b = -XW'(signed'({1'b0, price_rd_q}));
			op_c = best_q;
		end
	end

	assign sum = op_a + op_b;
	assign gt  = (sum > op_c);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: begin
				result_q <= '0;
				keep_q   <= '0;
			end
			ST_SELL: begin
				if (e_q == '0) begin
					keep_q <= '0;
				end else if (gt) begin
					keep_q <= sum[RW-1:0];
				end
			end
			ST_BUY: begin
				if ((e_q == '0) || gt) begin
					best_q <= sum;
				end
			end
			ST_TAIL: begin
				result_q <= keep_q;
			end
			ST_DONE: begin
				if (out_free) begin
					out_profit_q <= result_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			e_q         <= '0;
			rows_q      <= '0;
			first_row_q <= 1'b1;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In ST_DONE the result register is refilled instead whenever it frees up.
			if ((state_q != ST_DONE) && out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (count_q < MAX_LEN_C) begin
							count_q <= count_q + 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					e_q         <= '0;
					rows_q      <= '0;
					first_row_q <= 1'b1;
					changed_q   <= 1'b0;
					state_q     <= short_run ? ST_DONE : ST_SELL;
				end
				ST_SELL: begin
					if ((e_q != '0) && differs) begin
						changed_q <= 1'b1;
					end
					state_q <= ST_BUY;
				end
				ST_BUY: begin
					if (at_last) begin
						state_q <= ST_TAIL;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= ST_SELL;
					end
				end
				ST_TAIL: begin
					e_q         <= '0;
					rows_q      <= rows_q + 1'b1;
					first_row_q <= 1'b0;
					changed_q   <= 1'b0;
					if (!(changed_q || differs) || rows_done) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SELL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	`MPK_ASSERT(a_e_in_range, ((state_q == ST_SELL) || (state_q == ST_BUY)) |-> (e_q <= last_idx), "entry index ran past the loaded prices")
	`MPK_ASSERT(a_count_bound, count_q <= MAX_LEN_C, "price count exceeds the store depth")
	`MPK_ASSERT_NEXT(a_done_presents, (state_q == ST_DONE) && out_free, m_tvalid && (state_q == ST_LOAD), msg_a_done_presents)
	`MPK_ASSERT_NEXT(a_short_run, (state_q == ST_START) && short_run, (state_q == ST_DONE) && (result_q == '0), msg_a_short_run)

endmodule

FILE: tb/sv/max_profit_k_trades_dp_top_test.sv
// Self-checking testbench for max_profit_k_trades_dp_top: price sequences go in on the slave
// stream, and each profit result is checked against a behavioural model in a scoreboard class.
// Depends on mpk_dp_pkg and the RTL of max_profit_k_trades_dp_top.
`timescale 1ns / 1ps

module max_profit_k_trades_dp_top_test;

	localparam int MAX_LEN_DEF = mpk_dp_pkg::MAX_LEN_DEF;
	localparam int PRICE_W     = mpk_dp_pkg::PRICE_W;
	localparam int PROFIT_W    = mpk_dp_pkg::PROFIT_W;
	localparam int TRADES_W    = mpk_dp_pkg::TRADES_W;
	localparam int ACC_W       = mpk_dp_pkg::ACC_W;
	localparam int CFG_AW      = mpk_dp_pkg::CFG_AW;
	localparam int CFG_DW      = mpk_dp_pkg::CFG_DW;
	localparam int OUT_DW      = mpk_dp_pkg::OUT_DW;
	localparam logic [TRADES_W-1:0] TRADES_RST = mpk_dp_pkg::TRADES_RST;

	typedef logic signed [ACC_W-1:0] wide_t;
	typedef enum int {SHAPE_SCATTER, SHAPE_NARROW, SHAPE_ZIGZAG, SHAPE_FALLING} shape_t;

	localparam logic [CFG_AW-1:0] TRADES_ADDR = CFG_AW'(0);
	// Byte address of register index 1, which does not exist.
	localparam logic [CFG_AW-1:0] SPARE_ADDR  = CFG_AW'(4);
	localparam logic              CFG_WRITE   = 1'b1;
	localparam logic              CFG_READ    = 1'b0;

	class profit_scoreboard;
		logic [TRADES_W-1:0] trade_limit;
		logic [PRICE_W-1:0]  held_prices[$];
		logic [OUT_DW-1:0]   expected_profit[$];
		int                  mismatches;

		function new();
			trade_limit = TRADES_RST;
			mismatches  = 0;
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s at %0t: expected %0d, got %0d", what, $time, want, got);
		endfunction

		function void note_trades(logic [CFG_DW-1:0] data);
			trade_limit = data[TRADES_W-1:0];
		endfunction

		// Row by row over the allowed trades; stops once a row repeats the one before it.
		function logic [PROFIT_W-1:0] best_profit();
			logic [PROFIT_W-1:0] prev_row[];
			logic [PROFIT_W-1:0] this_row[];
			wide_t best_buy;
			wide_t sell;
			wide_t cand;
			int    n;
			int    row;
			int    e;
			bit    changed;
			n = held_prices.size();
			if (n < 2)
				return '0;
			prev_row = new[n];
			this_row = new[n];
			for (e = 0; e < n; e++)
				prev_row[e] = '0;
			for (row = 0; row < int'(trade_limit); row++) begin
				best_buy = -wide_t'(held_prices[0]);
				this_row[0] = '0;
				for (e = 1; e < n; e++) begin
					sell = wide_t'(held_prices[e]) + best_buy;
					if (sell > wide_t'(this_row[e-1]))
						this_row[e] = sell[PROFIT_W-1:0];
					else
						this_row[e] = this_row[e-1];
					cand = wide_t'(prev_row[e-1]) - wide_t'(held_prices[e]);
					if (cand > best_buy)
						best_buy = cand;
				end
				changed = 1'b0;
				for (e = 0; e < n; e++) begin
					if (this_row[e] != prev_row[e])
						changed = 1'b1;
					prev_row[e] = this_row[e];
				end
				if (!changed)
					break;
			end
			return prev_row[n-1];
		endfunction

		function void note_request(logic [PRICE_W-1:0] price, logic is_last);
			// Prices beyond the store depth are dropped, but the closing request still counts.
			if (held_prices.size() < MAX_LEN_DEF)
				held_prices = {held_prices, price};
			if (is_last) begin
				expected_profit = {expected_profit, OUT_DW'(best_profit())};
				held_prices.delete();
			end
		endfunction

		function void check_result(logic [OUT_DW-1:0] got);
			logic [OUT_DW-1:0] want;
			if (expected_profit.size() == 0) begin
				flag("profit with none outstanding", '0, got);
				return;
			end
			want = expected_profit.pop_front();
			if (got !== want)
				flag("profit", want, got);
		endfunction

		function int pending();
			return expected_profit.size();
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [PRICE_W-1:0]   s_tdata  = '0;    // price[15:0]
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_DW-1:0]    m_tdata;          // profit[25:0], zero filled
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [CFG_AW-1:0]    paddr    = '0;
	logic [CFG_DW-1:0]    pwdata   = '0;
	logic [CFG_DW-1:0]    prdata;
	logic                 pready;

	profit_scoreboard board;
	bit               send_calm;
	bit               take_calm;
	int               items_sent;

	max_profit_k_trades_dp_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Now and then switch between random waits and a stretch with no waits at all.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 15) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, 13));
	endfunction

	// Returns at the accepting edge with s_tvalid still high; the caller either sends the next
	// request or lowers s_tvalid in the same time step.
	task automatic send_price(input logic [PRICE_W-1:0] price, input logic is_last);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= price;
		s_tlast  <= is_last;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		board.note_request(price, is_last);
		items_sent++;
	endtask

	task automatic send_values(input int prices[$]);
		foreach (prices[i])
			send_price(PRICE_W'(prices[i]), i == prices.size() - 1);
	endtask

	task automatic send_sequence(input int len, input shape_t shape);
		logic [PRICE_W-1:0] base;
		logic [PRICE_W-1:0] price;
		base = PRICE_W'($urandom_range(0, 65532));
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_NARROW: begin
					price = base + PRICE_W'($urandom_range(0, 3));
				end
				SHAPE_ZIGZAG: begin
					price = (i % 2 == 0) ? PRICE_W'($urandom_range(0, 100))
						: PRICE_W'($urandom_range(65400, 65535));
				end
				SHAPE_FALLING: begin
					price = PRICE_W'(65535 - i * 300 - int'($urandom_range(0, 299)));
				end
				default: begin
					price = PRICE_W'($urandom_range(0, 65535));
				end
			endcase
			send_price(price, i == len - 1);
		end
	endtask

	// Lowers s_tvalid and waits until every profit has come back and the block is idle.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_access(input logic write, input logic [CFG_AW-1:0] addr,
			input logic [CFG_DW-1:0] data, output logic [CFG_DW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_trades_readback();
		logic [CFG_DW-1:0] rdata;
		cfg_access(CFG_READ, TRADES_ADDR, '0, rdata);
		if (rdata !== CFG_DW'(board.trade_limit))
			board.flag("max_trades readback", CFG_DW'(board.trade_limit), rdata);
	endtask

	// Upper bits of the write data are random; only the low ten bits belong to the register.
	task automatic set_trades(input int trades);
		logic [CFG_DW-1:0] data;
		logic [CFG_DW-1:0] rdata;
		settle();
		data = ($urandom() & ~CFG_DW'(1023)) | CFG_DW'(trades);
		cfg_access(CFG_WRITE, TRADES_ADDR, data, rdata);
		board.note_trades(data);
		if ($urandom_range(0, 3) == 0)
			cfg_access(CFG_WRITE, SPARE_ADDR, $urandom(), rdata);
		check_trades_readback();
	endtask

	initial begin : take_results
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(take_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1) @(posedge clk);
			board.check_result(m_tdata);
		end
	end

	initial begin : watchdog
		#25_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int     prices[$];
		int     random_start;
		int     sequences;
		int     long_left;
		int     len;
		int     trades;
		shape_t shape;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		check_trades_readback();

		// One trade allowed after reset: widest swing, a lone price, then a mixed run.
		prices = '{0, 65535};
		send_values(prices);
		prices = '{65535};
		send_values(prices);
		prices = '{100, 50, 200, 10, 300};
		send_values(prices);

		set_trades(0);
		prices = '{1, 65535, 0, 65535};
		send_values(prices);

		set_trades(1023);
		prices = '{0, 65535, 0, 65535, 0, 65535};
		send_values(prices);
		prices = '{65535, 40000, 0};
		send_values(prices);

		random_start = items_sent;
		sequences    = 0;
		long_left    = 6;
		while (items_sent - random_start < 560 || sequences < 40) begin
			case ($urandom_range(0, 9))
				0: trades = 0;
				1: trades = 1023;
				2, 3: trades = $urandom_range(1, 4);
				4, 5: trades = $urandom_range(0, 1023);
				default: trades = $urandom_range(1, 16);
			endcase
			set_trades(trades);
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(0, 15))
					0: begin
						if (long_left > 0) begin
							len = $urandom_range(25, 200);
							long_left--;
						end else begin
							len = $urandom_range(1, 24);
						end
					end
					1: len = 1;
					2: len = 2;
					default: len = $urandom_range(1, 24);
				endcase
				shape = ($urandom_range(0, 1) == 0) ? SHAPE_SCATTER : shape_t'($urandom_range(0, 3));
				send_sequence(len, shape);
				sequences++;
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mpk_dp_pkg.sv
hw/rtl/max_profit_k_trades_dp_top.sv
tb/sv/max_profit_k_trades_dp_top_test.sv
